// ===== rtl/json_syntax_validator_assert.svh =====
// assertion macros used by the port checker file
// no dependencies
`ifndef JSON_SYNTAX_VALIDATOR_ASSERT_SVH
`define JSON_SYNTAX_VALIDATOR_ASSERT_SVH

// implication checked every clock, quiet during reset
`define JSV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define JSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/jsv_pkg.sv =====
// shared types and constants for the json syntax validator
// no dependencies
`timescale 1ns / 1ps
package jsv_pkg;

  localparam int unsigned DepthMax = 32;
  localparam int unsigned TextMax  = 1048576;
  localparam int unsigned PosW     = 21;
  localparam int unsigned DepthW   = 6;
  localparam int unsigned StackAw  = $clog2(DepthMax);

  typedef enum logic [4:0] {
    M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_OBJ_KEY, M_COLON, M_AFTER_VALUE, M_AFTER_TOP,
    S_STR, S_ESC, S_HEX, S_SUR_BS, S_SUR_U, M_LIT,
    N_SIGN, N_ZERO, N_INT, N_DOT, N_FRAC, N_EXP, N_EXPS, N_EXPD
  } mode_e;

  typedef enum logic [4:0] {
    ERR_NONE      = 5'd0,
    ERR_VALUE     = 5'd1,
    ERR_LITERAL   = 5'd2,
    ERR_OBJ_DEEP  = 5'd3,
    ERR_KEY       = 5'd4,
    ERR_COLON     = 5'd5,
    ERR_OBJ_SEP   = 5'd6,
    ERR_ARR_DEEP  = 5'd7,
    ERR_ARR_SEP   = 5'd8,
    ERR_LONE_HIGH = 5'd9,
    ERR_BAD_LOW   = 5'd10,
    ERR_LONE_LOW  = 5'd11,
    ERR_ESCAPE    = 5'd12,
    ERR_CTRL      = 5'd13,
    ERR_UNTERM    = 5'd14,
    ERR_SHORT_HEX = 5'd15,
    ERR_NON_HEX   = 5'd16,
    ERR_INT       = 5'd17,
    ERR_FRAC      = 5'd18,
    ERR_EXP       = 5'd19,
    ERR_TRAILING  = 5'd20
  } err_e;

  typedef enum logic [0:0] {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  // stack push request from the parse step
  typedef struct packed {
    logic               push;
    logic [StackAw-1:0] addr;
    logic               kind;
  } stack_wr_t;

  // literal letter lookup: kind 0 true, 1 false, 2 null
  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      2'd0: case (idx)
        3'd0: ch = "t"; 3'd1: ch = "r"; 3'd2: ch = "u"; 3'd3: ch = "e";
        default: ch = 8'h00;
      endcase
      2'd1: case (idx)
        3'd0: ch = "f"; 3'd1: ch = "a"; 3'd2: ch = "l"; 3'd3: ch = "s"; 3'd4: ch = "e";
        default: ch = 8'h00;
      endcase
      2'd2: case (idx)
        3'd0: ch = "n"; 3'd1: ch = "u"; 3'd2: ch = "l"; 3'd3: ch = "l";
        default: ch = 8'h00;
      endcase
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    return (kind == 2'd1) ? 3'd5 : 3'd4;
  endfunction

endpackage

// ===== rtl/jsv_stack.sv =====
// container kind stack: one bit per nesting level, 0 object, 1 array
// uses jsv_pkg
`timescale 1ns / 1ps
module jsv_stack (
  input  logic                       clk_i,
  input  jsv_pkg::stack_wr_t         wr_i,
  input  logic [jsv_pkg::DepthW-1:0] depth_i,
  output logic                       top_kind_o
);
  import jsv_pkg::*;

  logic [DepthMax-1:0] kind_q;
  logic [StackAw-1:0]  top_addr;

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      kind_q[wr_i.addr] <= wr_i.kind;
    end
  end

  assign top_addr = StackAw'(depth_i - DepthW'(1));
  // depth 0 reads as object, matching the top-level separator rules
  assign top_kind_o = (depth_i == '0) ? 1'b0 : kind_q[top_addr];

endmodule

// ===== rtl/jsv_parser.sv =====
// per-byte grammar step: state registers and next-state logic
// uses jsv_pkg and jsv_stack
`timescale 1ns / 1ps
module jsv_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     cmd_i,
  input  logic [7:0]               byte_i,
  output logic                     ok_o,
  output logic [4:0]               err_code_o,
  output logic [jsv_pkg::PosW-1:0] err_off_o
);
  import jsv_pkg::*;

  mode_e             mode_q, mode_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic [15:0]       hex_q, hex_d;
  logic [2:0]        hcnt_q, hcnt_d;
  logic              hi_q, hi_d;
  logic [4:0]        lit_q, lit_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   tok_q, tok_d;
  logic [4:0]        ecode_q, ecode_d;
  logic [PosW-1:0]   eoff_q, eoff_d;
  logic              key_q, key_d;
  logic              hbad_q, hbad_d;
  stack_wr_t         swr;
  logic              top_kind;

  jsv_stack u_stack (
    .clk_i      (clk_i),
    .wr_i       (swr),
    .depth_i    (depth_q),
    .top_kind_o (top_kind)
  );

  logic [7:0]      c;
  logic [PosW-1:0] pos1;
  logic            ws, dig, hexv, c_end;
  logic [3:0]      hval;
  logic [15:0]     hnew;
  logic [1:0]      lkind;
  logic [2:0]      lidx;
  mode_e           done_mode;
  logic            err;
  logic [4:0]      ec;
  logic [PosW-1:0] eo;
  logic            vs_go;
  logic            num_term;

  assign c    = byte_i;
  assign pos1 = (pos_q < PosW'(TextMax)) ? pos_q + PosW'(1) : PosW'(TextMax);
  assign ws   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  assign dig  = (c >= "0") && (c <= "9");
  assign lkind = lit_q[4:3];
  assign lidx  = lit_q[2:0];

  always_comb begin
    hexv = 1'b1;
    hval = 4'd0;
    if (dig) hval = 4'(c - "0");
    else if (c >= "a" && c <= "f") hval = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") hval = 4'(c - "A" + 8'd10);
    else hexv = 1'b0;
  end
  assign hnew = hexv ? {hex_q[11:0], hval} : hex_q;

  // value completion moves to after-top or after-value by depth
  function automatic mode_e vdone(input logic [DepthW-1:0] d);
    return (d == '0) ? M_AFTER_TOP : M_AFTER_VALUE;
  endfunction

  always_comb begin
    mode_d  = mode_q;  depth_d = depth_q; hex_d = hex_q; hcnt_d = hcnt_q;
    hi_d    = hi_q;    lit_d   = lit_q;   pos_d = pos_q; tok_d  = tok_q;
    ecode_d = ecode_q; eoff_d  = eoff_q;  key_d = key_q; hbad_d = hbad_q;
    swr     = '{push: 1'b0, addr: StackAw'(depth_q), kind: 1'b0};
    err = 1'b0; ec = ERR_NONE; eo = pos_q;
    vs_go = 1'b0; num_term = 1'b0; c_end = 1'b0;
    done_mode = vdone(depth_q);
    ok_o = 1'b0;

    if (cmd_i == CMD_END) begin
      // end of text, numbers close themselves here
      case (mode_q)
        M_AFTER_TOP: ;
        N_ZERO, N_INT, N_FRAC, N_EXPD:
          if (depth_q != '0) begin
            err = 1'b1; ec = top_kind ? ERR_ARR_SEP : ERR_OBJ_SEP;
          end
        M_OBJ_FIRST, M_OBJ_KEY: begin err = 1'b1; ec = ERR_KEY; end
        M_COLON:        begin err = 1'b1; ec = ERR_COLON; end
        M_AFTER_VALUE:  begin err = 1'b1; ec = top_kind ? ERR_ARR_SEP : ERR_OBJ_SEP; end
        S_STR, S_ESC:   begin err = 1'b1; ec = ERR_UNTERM; end
        S_HEX:          begin err = 1'b1; ec = ERR_SHORT_HEX; eo = tok_q; end
        S_SUR_BS, S_SUR_U: begin err = 1'b1; ec = ERR_LONE_HIGH; eo = tok_q; end
        M_LIT:          begin err = 1'b1; ec = ERR_LITERAL; eo = tok_q; end
        N_SIGN:         begin err = 1'b1; ec = ERR_INT; end
        N_DOT:          begin err = 1'b1; ec = ERR_FRAC; end
        N_EXP, N_EXPS:  begin err = 1'b1; ec = ERR_EXP; end
        default:        begin err = 1'b1; ec = ERR_VALUE; end
      endcase
      c_end = 1'b1;
    end else begin
      pos_d = pos1;
      case (mode_q)
        M_VALUE: vs_go = 1'b1;
        M_ARR_FIRST:
          if (c == "]") begin
            depth_d = depth_q - DepthW'(1); mode_d = vdone(depth_q - DepthW'(1));
          end else vs_go = 1'b1;
        M_OBJ_FIRST, M_OBJ_KEY:
          if (ws) ;
          else if (c == "}" && mode_q == M_OBJ_FIRST) begin
            depth_d = depth_q - DepthW'(1); mode_d = vdone(depth_q - DepthW'(1));
          end else if (c == "\"") begin key_d = 1'b1; mode_d = S_STR; end
          else begin err = 1'b1; ec = ERR_KEY; end
        M_COLON:
          if (ws) ;
          else if (c == ":") mode_d = M_VALUE;
          else begin err = 1'b1; ec = ERR_COLON; end
        M_AFTER_VALUE:
          if (ws) ;
          else if (c == ",") mode_d = top_kind ? M_VALUE : M_OBJ_KEY;
          else if (c == (top_kind ? 8'h5D : 8'h7D)) begin
            depth_d = depth_q - DepthW'(1); mode_d = vdone(depth_q - DepthW'(1));
          end else begin err = 1'b1; ec = top_kind ? ERR_ARR_SEP : ERR_OBJ_SEP; end
        M_AFTER_TOP:
          if (!ws) begin err = 1'b1; ec = ERR_TRAILING; end
        S_STR:
          if (c == "\"") mode_d = key_q ? M_COLON : done_mode;
          else if (c == "\\") mode_d = S_ESC;
          else if (c < 8'h20) begin err = 1'b1; ec = ERR_CTRL; end
        S_ESC:
          if (c inside {"\"", "\\", "/", "b", "f", "n", "r", "t"}) mode_d = S_STR;
          else if (c == "u") begin
            tok_d = pos1; hex_d = '0; hcnt_d = '0; hbad_d = 1'b0; mode_d = S_HEX;
          end else begin err = 1'b1; ec = ERR_ESCAPE; eo = pos1; end
        S_HEX: begin
          hex_d  = hnew;
          hbad_d = hbad_q | ~hexv;
          hcnt_d = hcnt_q + 3'd1;
          if (hcnt_q == 3'd3) begin
            if (hbad_q || !hexv) begin err = 1'b1; ec = ERR_NON_HEX; eo = tok_q; end
            else if (hi_q) begin
              if (hnew >= 16'hDC00 && hnew <= 16'hDFFF) begin
                hi_d = 1'b0; mode_d = S_STR;
              end else begin err = 1'b1; ec = ERR_BAD_LOW; eo = pos1; end
            end else if (hnew >= 16'hD800 && hnew <= 16'hDBFF) begin
              hi_d = 1'b1; tok_d = pos1; mode_d = S_SUR_BS;
            end else if (hnew >= 16'hDC00 && hnew <= 16'hDFFF) begin
              err = 1'b1; ec = ERR_LONE_LOW; eo = pos1;
            end else mode_d = S_STR;
          end
        end
        S_SUR_BS:
          if (c == "\\") mode_d = S_SUR_U;
          else begin err = 1'b1; ec = ERR_LONE_HIGH; eo = tok_q; end
        S_SUR_U:
          if (c == "u") begin
            tok_d = pos1; hex_d = '0; hcnt_d = '0; hbad_d = 1'b0; mode_d = S_HEX;
          end else begin err = 1'b1; ec = ERR_LONE_HIGH; eo = tok_q; end
        M_LIT:
          if (lkind == 2'd3 || lidx >= lit_len(lkind) || c != lit_char(lkind, lidx)) begin
            err = 1'b1; ec = ERR_LITERAL; eo = tok_q;
          end else begin
            lit_d = {lkind, lidx + 3'd1};
            if (lidx + 3'd1 == lit_len(lkind)) mode_d = done_mode;
          end
        N_SIGN:
          if (c == "0") mode_d = N_ZERO;
          else if (dig) mode_d = N_INT;
          else begin err = 1'b1; ec = ERR_INT; end
        N_ZERO, N_INT, N_FRAC:
          if (dig && mode_q != N_ZERO) ;
          else if (c == "." && mode_q != N_FRAC) mode_d = N_DOT;
          else if (c == "e" || c == "E") mode_d = N_EXP;
          else num_term = 1'b1;
        N_DOT:
          if (dig) mode_d = N_FRAC;
          else begin err = 1'b1; ec = ERR_FRAC; end
        N_EXP:
          if (c == "+" || c == "-") mode_d = N_EXPS;
          else if (dig) mode_d = N_EXPD;
          else begin err = 1'b1; ec = ERR_EXP; end
        N_EXPS:
          if (dig) mode_d = N_EXPD;
          else begin err = 1'b1; ec = ERR_EXP; end
        N_EXPD:
          if (!dig) num_term = 1'b1;
        default: begin err = 1'b1; ec = ERR_VALUE; end
      endcase

      // a number ends: the same byte goes to after-top or after-value
      if (num_term) begin
        mode_d = done_mode;
        if (depth_q == '0) begin
          if (!ws) begin err = 1'b1; ec = ERR_TRAILING; end
        end else if (ws) ;
        else if (c == ",") mode_d = top_kind ? M_VALUE : M_OBJ_KEY;
        else if (c == (top_kind ? 8'h5D : 8'h7D)) begin
          depth_d = depth_q - DepthW'(1); mode_d = vdone(depth_q - DepthW'(1));
        end else begin err = 1'b1; ec = top_kind ? ERR_ARR_SEP : ERR_OBJ_SEP; end
      end

      if (vs_go) begin
        if (ws) ;
        else if (c == "{" || c == "[") begin
          if (depth_q >= DepthW'(DepthMax)) begin
            err = 1'b1; ec = (c == "[") ? ERR_ARR_DEEP : ERR_OBJ_DEEP;
          end else begin
            swr = '{push: 1'b1, addr: StackAw'(depth_q), kind: (c == "[")};
            depth_d = depth_q + DepthW'(1);
            mode_d = (c == "[") ? M_ARR_FIRST : M_OBJ_FIRST;
          end
        end else if (c == "\"") begin key_d = 1'b0; mode_d = S_STR; end
        else if (c == "t" || c == "f" || c == "n") begin
          lit_d = {(c == "t") ? 2'd0 : ((c == "f") ? 2'd1 : 2'd2), 3'd1};
          tok_d = pos_q; mode_d = M_LIT;
        end else if (c == "-") mode_d = N_SIGN;
        else if (c == "0") mode_d = N_ZERO;
        else if (dig) mode_d = N_INT;
        else begin err = 1'b1; ec = ERR_VALUE; end
      end
    end

    // after an error the state freezes, only the position moves
    if (ecode_q != ERR_NONE) begin
      mode_d = mode_q; depth_d = depth_q; hex_d = hex_q; hcnt_d = hcnt_q;
      hi_d = hi_q; lit_d = lit_q; tok_d = tok_q; key_d = key_q; hbad_d = hbad_q;
      swr.push = 1'b0;
    end else if (err) begin
      ecode_d = ec; eoff_d = eo;
    end

    err_code_o = ecode_d;
    err_off_o  = eoff_d;
    ok_o       = c_end && (ecode_d == ERR_NONE);

    if (c_end) begin
      mode_d = M_VALUE; depth_d = '0; hex_d = '0; hcnt_d = '0; hi_d = 1'b0;
      lit_d = '0; pos_d = '0; tok_d = '0; ecode_d = ERR_NONE; eoff_d = '0;
      key_d = 1'b0; hbad_d = 1'b0; swr.push = 1'b0;
    end
    if (!step_i) swr.push = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_VALUE; depth_q <= '0; hex_q <= '0; hcnt_q <= '0; hi_q <= 1'b0;
      lit_q <= '0; pos_q <= '0; tok_q <= '0; ecode_q <= ERR_NONE; eoff_q <= '0;
      key_q <= 1'b0; hbad_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d; depth_q <= depth_d; hex_q <= hex_d; hcnt_q <= hcnt_d;
      hi_q <= hi_d; lit_q <= lit_d; pos_q <= pos_d; tok_q <= tok_d;
      ecode_q <= ecode_d; eoff_q <= eoff_d; key_q <= key_d; hbad_q <= hbad_d;
    end
  end

endmodule

// ===== rtl/json_syntax_validator.sv =====
// top level of the streaming json syntax validator
// uses jsv_pkg and jsv_parser
`timescale 1ns / 1ps
// channel | valid           | stall          | payload
// in      | in_valid_i      | in_stall_o     | cmd_i, text_byte_i
// out     | out_valid_o     | out_stall_i    | done_res_o, accepted_o, error_code_o,
//         |                 |                | error_offset_o
// the grammar step is combinational in the cycle the byte is taken, and its result lands in
// the output register on the edge that takes the byte
// reset clears parse state, the error record and the output valid
// a stalled output holds its result; input stalls only while that result is unread
module json_syntax_validator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic [7:0]               text_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     done_res_o,
  output logic                     accepted_o,
  output logic [4:0]               error_code_o,
  output logic [jsv_pkg::PosW-1:0] error_offset_o
);
  import jsv_pkg::*;

  logic            step;
  logic            ok;
  logic [4:0]      ecode;
  logic [PosW-1:0] eoff;
  logic            out_valid_q;
  logic            done_q, acc_q;
  logic [4:0]      code_q;
  logic [PosW-1:0] off_q;

  // input is taken whenever the output register is free or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  jsv_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .cmd_i      (cmd_i),
    .byte_i     (text_byte_i),
    .ok_o       (ok),
    .err_code_o (ecode),
    .err_off_o  (eoff)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      done_q <= (cmd_i == CMD_END);
      acc_q  <= ok;
      code_q <= ecode;
      off_q  <= eoff;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign done_res_o     = done_q;
  assign accepted_o     = acc_q;
  assign error_code_o   = code_q;
  assign error_offset_o = off_q;

endmodule

// ===== rtl/jsv_checker.sv =====
// port-level checks for the json syntax validator, bound to the top level
// uses json_syntax_validator_assert.svh and jsv_pkg
`timescale 1ns / 1ps
`include "json_syntax_validator_assert.svh"
module jsv_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        done_res_o,
  input logic        accepted_o,
  input logic [4:0]  error_code_o
);
  import jsv_pkg::*;

  logic clean_done;
  logic held;

  assign clean_done = done_res_o && (error_code_o == ERR_NONE);
  assign held       = out_valid_o && out_stall_i;

  `JSV_ASSERT_IMP(a_acc_clean, clk_i, rst_ni, out_valid_o && accepted_o, clean_done)
  `JSV_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, held)
  `JSV_ASSERT_NEXT(a_take_gives, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)
  `JSV_ASSERT_NEXT(a_hold, clk_i, rst_ni, held, out_valid_o && $stable(error_code_o))
endmodule

bind json_syntax_validator jsv_port_checker u_jsv_port_checker (.*);

// ===== test/jsv_checker.sv =====
// transaction checker for the json syntax validator: predicts each result and compares
// depends on jsv_pkg
`timescale 1ns / 1ps
module jsv_checker
  import jsv_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  logic            cmd_i,
  input  logic [7:0]      text_byte_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  logic            done_res_i,
  input  logic            accepted_i,
  input  logic [4:0]      error_code_i,
  input  logic [PosW-1:0] error_offset_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              verdicts_o
);

  typedef struct packed {
    logic            done;
    logic            acc;
    logic [4:0]      code;
    logic [PosW-1:0] off;
  } verdict_t;

  verdict_t expected_q[$];

  // predictor state
  mode_e           mode;
  logic [5:0]      depth;
  logic            kind_stk [DepthMax];
  logic [15:0]     hacc;
  int              hcnt;
  bit              hsur;
  logic [1:0]      lkind;
  logic [2:0]      lidx;
  logic [PosW-1:0] bpos;
  logic [PosW-1:0] tstart;
  err_e            ecode;
  logic [PosW-1:0] eoff;
  bit              is_key;
  bit              hbad;

  string words [3] = '{"true", "false", "null"};

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d;
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic clear_parse();
    mode = M_VALUE; depth = 0; hacc = 0; hcnt = 0; hsur = 0;
    lkind = 0; lidx = 0; bpos = 0; tstart = 0; ecode = ERR_NONE; eoff = 0;
    is_key = 0; hbad = 0;
    foreach (kind_stk[i]) kind_stk[i] = 1'b0;
  endtask

  function automatic void flag(err_e code, logic [PosW-1:0] off);
    if (ecode == ERR_NONE) begin
      ecode = code;
      eoff  = off;
    end
  endfunction

  function automatic void end_value();
    mode = (depth == 0) ? M_AFTER_TOP : M_AFTER_VALUE;
  endfunction

  function automatic logic inner_is_array();
    if (depth == 0 || depth > DepthMax) return 1'b0;
    return kind_stk[depth - 1];
  endfunction

  task automatic open_nest(logic arr, logic [PosW-1:0] pos);
    if (depth + 1 > DepthMax) begin
      flag(arr ? ERR_ARR_DEEP : ERR_OBJ_DEEP, pos);
    end else begin
      kind_stk[depth] = arr;
      depth++;
      mode = arr ? M_ARR_FIRST : M_OBJ_FIRST;
    end
  endtask

  task automatic begin_value(logic [7:0] c, logic [PosW-1:0] pos);
    if (is_space(c)) return;
    if (c == "{") open_nest(1'b0, pos);
    else if (c == "[") open_nest(1'b1, pos);
    else if (c == "\"") begin
      is_key = 0; mode = S_STR;
    end else if (c == "t" || c == "f" || c == "n") begin
      lkind = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
      lidx = 1; tstart = pos; mode = M_LIT;
    end else if (c == "-") mode = N_SIGN;
    else if (c == "0") mode = N_ZERO;
    else if (is_num(c)) mode = N_INT;
    else flag(ERR_VALUE, pos);
  endtask

  task automatic begin_hex(logic [PosW-1:0] at);
    tstart = at; hacc = 0; hcnt = 0; hbad = 0; mode = S_HEX;
  endtask

  task automatic take_hex(logic [7:0] c, logic [PosW-1:0] pos1);
    int v;
    v = hex_of(c);
    if (v < 0) hbad = 1;
    else hacc = {hacc[11:0], v[3:0]};
    hcnt++;
    if (hcnt < 4) return;
    if (hbad) flag(ERR_NON_HEX, tstart);
    else if (hsur) begin
      if (hacc >= 16'hdc00 && hacc <= 16'hdfff) begin
        hsur = 0; mode = S_STR;
      end else flag(ERR_BAD_LOW, pos1);
    end else if (hacc >= 16'hd800 && hacc <= 16'hdbff) begin
      hsur = 1; tstart = pos1; mode = S_SUR_BS;
    end else if (hacc >= 16'hdc00 && hacc <= 16'hdfff) flag(ERR_LONE_LOW, pos1);
    else mode = S_STR;
  endtask

  task automatic step_byte(logic [7:0] c, logic [PosW-1:0] pos, logic [PosW-1:0] pos1);
    bit again;
    logic arr;
    again = 1;
    while (again && ecode == ERR_NONE) begin
      again = 0;
      case (mode)
        M_VALUE: begin_value(c, pos);
        M_ARR_FIRST: begin
          if (c == "]") begin
            depth--; end_value();
          end else begin_value(c, pos);
        end
        M_OBJ_FIRST, M_OBJ_KEY: begin
          if (!is_space(c)) begin
            if (c == "}" && mode == M_OBJ_FIRST) begin
              depth--; end_value();
            end else if (c == "\"") begin
              is_key = 1; mode = S_STR;
            end else flag(ERR_KEY, pos);
          end
        end
        M_COLON: begin
          if (!is_space(c)) begin
            if (c == ":") mode = M_VALUE;
            else flag(ERR_COLON, pos);
          end
        end
        M_AFTER_VALUE: begin
          arr = inner_is_array();
          if (!is_space(c)) begin
            if (c == ",") mode = arr ? M_VALUE : M_OBJ_KEY;
            else if (c == (arr ? "]" : "}")) begin
              depth--; end_value();
            end else flag(arr ? ERR_ARR_SEP : ERR_OBJ_SEP, pos);
          end
        end
        M_AFTER_TOP: if (!is_space(c)) flag(ERR_TRAILING, pos);
        S_STR: begin
          if (c == "\"") begin
            if (is_key) mode = M_COLON;
            else end_value();
          end else if (c == "\\") mode = S_ESC;
          else if (c < 8'h20) flag(ERR_CTRL, pos);
        end
        S_ESC: begin
          if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
              c == "n" || c == "r" || c == "t") mode = S_STR;
          else if (c == "u") begin_hex(pos1);
          else flag(ERR_ESCAPE, pos1);
        end
        S_HEX: take_hex(c, pos1);
        S_SUR_BS: if (c == "\\") mode = S_SUR_U; else flag(ERR_LONE_HIGH, tstart);
        S_SUR_U: if (c == "u") begin_hex(pos1); else flag(ERR_LONE_HIGH, tstart);
        M_LIT: begin
          if (c != words[lkind][lidx]) flag(ERR_LITERAL, tstart);
          else begin
            lidx++;
            if (lidx == words[lkind].len()) end_value();
          end
        end
        N_SIGN: begin
          if (c == "0") mode = N_ZERO;
          else if (is_num(c)) mode = N_INT;
          else flag(ERR_INT, pos);
        end
        N_ZERO, N_INT, N_FRAC: begin
          if (!(is_num(c) && mode != N_ZERO)) begin
            if (c == "." && mode != N_FRAC) mode = N_DOT;
            else if (c == "e" || c == "E") mode = N_EXP;
            else begin
              end_value(); again = 1;
            end
          end
        end
        N_DOT: if (is_num(c)) mode = N_FRAC; else flag(ERR_FRAC, pos);
        N_EXP: begin
          if (c == "+" || c == "-") mode = N_EXPS;
          else if (is_num(c)) mode = N_EXPD;
          else flag(ERR_EXP, pos);
        end
        N_EXPS: if (is_num(c)) mode = N_EXPD; else flag(ERR_EXP, pos);
        N_EXPD: begin
          if (!is_num(c)) begin
            end_value(); again = 1;
          end
        end
        default: flag(ERR_VALUE, pos);
      endcase
    end
  endtask

  // end of text: settle a trailing number, then name what is missing
  function automatic bit close_text(logic [PosW-1:0] pos);
    forever begin
      if (ecode != ERR_NONE) return 0;
      case (mode)
        M_AFTER_TOP: return 1;
        N_ZERO, N_INT, N_FRAC, N_EXPD: end_value();
        M_OBJ_FIRST, M_OBJ_KEY: flag(ERR_KEY, pos);
        M_COLON: flag(ERR_COLON, pos);
        M_AFTER_VALUE: flag(inner_is_array() ? ERR_ARR_SEP : ERR_OBJ_SEP, pos);
        S_STR, S_ESC: flag(ERR_UNTERM, pos);
        S_HEX: flag(ERR_SHORT_HEX, tstart);
        S_SUR_BS, S_SUR_U: flag(ERR_LONE_HIGH, tstart);
        M_LIT: flag(ERR_LITERAL, tstart);
        N_SIGN: flag(ERR_INT, pos);
        N_DOT: flag(ERR_FRAC, pos);
        N_EXP, N_EXPS: flag(ERR_EXP, pos);
        default: flag(ERR_VALUE, pos);
      endcase
    end
  endfunction

  task automatic predict(logic cmd, logic [7:0] c);
    verdict_t v;
    logic [PosW-1:0] pos, pos1;
    pos  = bpos;
    pos1 = (pos < PosW'(TextMax)) ? pos + PosW'(1) : PosW'(TextMax);
    v = '0;
    if (cmd == CMD_BYTE) begin
      step_byte(c, pos, pos1);
      bpos = pos1;
    end else begin
      v.done = 1;
      v.acc  = close_text(pos);
    end
    v.code = ecode;
    v.off  = eoff;
    expected_q.insert(expected_q.size(), v);
    if (cmd == CMD_END) clear_parse();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      clear_parse();
      expected_q.delete();
      fail_count_o <= 0;
      verdicts_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result at %0t", $realtime);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = expected_q.pop_front();
          if (exp_v.done) verdicts_o <= verdicts_o + 1;
          if (exp_v != {done_res_i, accepted_i, error_code_i, error_offset_i}) begin
            if (fail_count_o < 10)
              $display("mismatch at %0t: done %0d/%0d acc %0d/%0d code %0d/%0d off %0d/%0d",
                       $realtime, exp_v.done, done_res_i, exp_v.acc, accepted_i,
                       exp_v.code, error_code_i, exp_v.off, error_offset_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict(cmd_i, text_byte_i);
    end
  end

  assign pending_o = expected_q.size();

endmodule

// ===== test/tb_json_syntax_validator.sv =====
// testbench top for the json syntax validator: directed and random json texts
// depends on jsv_pkg, json_syntax_validator and jsv_checker
`timescale 1ns / 1ps
module tb_json_syntax_validator;
  import jsv_pkg::*;

  localparam int CycleLimit = 400000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            cmd_i = CMD_BYTE;
  logic [7:0]      text_byte_i = 8'h00;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic            done_res_o;
  logic            accepted_o;
  logic [4:0]      error_code_o;
  logic [PosW-1:0] error_offset_o;

  int fail_count, pending, verdicts;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int texts_sent = 0;
  int cycles = 0;

  // text under construction
  logic [7:0] txt [$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  json_syntax_validator dut (.*);

  jsv_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .text_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .done_res_i(done_res_o),
    .accepted_i(accepted_o), .error_code_i(error_code_o),
    .error_offset_i(error_offset_o),
    .fail_count_o(fail_count), .pending_o(pending), .verdicts_o(verdicts)
  );

  // receiver back-pressure, redrawn each cycle
  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // sender idles cycle by cycle, then one transaction on the input channel
  task automatic send_item(logic cmd, logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i  <= 1'b0;
      text_byte_i <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    text_byte_i <= b;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    items_sent++;
  endtask

  task automatic send_text();
    foreach (txt[i]) send_item(CMD_BYTE, txt[i]);
    send_item(CMD_END, 8'($urandom_range(255)));
    texts_sent++;
    txt.delete();
  endtask

  function automatic void add_byte(logic [7:0] b);
    txt.insert(txt.size(), b);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_ws();
    logic [7:0] spaces [4] = '{8'h20, 8'h09, 8'h0a, 8'h0d};
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      add_byte(spaces[$urandom_range(3)]);
  endfunction

  function automatic logic [7:0] hex_digit();
    string h = "0123456789abcdefABCDEF";
    if ($urandom_range(19) == 0) return 8'($urandom_range(255));  // occasional non-hex
    return h[$urandom_range(21)];
  endfunction

  function automatic void add_string();
    int n;
    logic [7:0] c;
    string esc = "\"\\/bfnrt";
    string hi_nib = "89AB";
    string lo_nib = "CDEF";
    n = $urandom_range(0, 5);
    add_byte("\"");
    repeat (n) begin
      case ($urandom_range(9))
        0: begin
          add_byte("\\");
          add_byte(esc[$urandom_range(7)]);
        end
        1: begin
          add_str("\\u");
          repeat (4) add_byte(hex_digit());
        end
        2: begin
          // surrogate pair with random low bits
          add_str("\\uD");
          add_byte(hi_nib[$urandom_range(3)]);
          repeat (2) add_byte(hex_digit());
          add_str("\\uD");
          add_byte(lo_nib[$urandom_range(3)]);
          repeat (2) add_byte(hex_digit());
        end
        default: begin
          c = 8'($urandom_range(8'h20, 8'hff));
          if (c == "\"" || c == "\\") c = "a";
          add_byte(c);
        end
      endcase
    end
    add_byte("\"");
  endfunction

  function automatic void add_number();
    if ($urandom_range(1)) add_byte("-");
    if ($urandom_range(3) == 0) add_byte("0");
    else begin
      add_byte(8'($urandom_range("1", "9")));
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(2) == 0) begin
      add_byte(".");
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(3) == 0) begin
      add_byte($urandom_range(1) ? "e" : "E");
      case ($urandom_range(2))
        0: add_byte("+");
        1: add_byte("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range("0", "9")));
    end
  endfunction

  function automatic string words_pick();
    case ($urandom_range(2))
      0: return "true";
      1: return "false";
      default: return "null";
    endcase
  endfunction

  function automatic void add_value(int lvl);
    int r, n;
    r = (lvl >= 3) ? $urandom_range(2, 5) : $urandom_range(0, 5);
    add_ws();
    case (r)
      0: begin
        add_byte("{");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) add_byte(",");
          add_ws(); add_string(); add_ws(); add_byte(":");
          add_value(lvl + 1);
        end
        add_ws();
        add_byte("}");
      end
      1: begin
        add_byte("[");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) add_byte(",");
          add_value(lvl + 1);
        end
        add_ws();
        add_byte("]");
      end
      2: add_string();
      3: add_number();
      default: add_str(words_pick());
    endcase
    add_ws();
  endfunction

  // nesting just below, at or past the depth limit
  function automatic void add_deep();
    int n;
    bit obj;
    n = $urandom_range(31, 34);
    obj = $urandom_range(1);
    repeat (n) begin
      if (obj) add_str("{\"k\":");
      else add_str("[");
    end
    add_str("0");
    repeat (n) begin
      if (obj) add_str("}");
      else add_str("]");
    end
  endfunction

  task automatic random_text();
    int k;
    if ($urandom_range(15) == 0) add_deep();
    else add_value(0);
    // most texts stay well formed; the rest are damaged
    case ($urandom_range(9))
      0, 1: txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
      2: begin
        k = $urandom_range(txt.size() - 1);
        while (txt.size() > k) void'(txt.pop_back());
      end
      3: add_byte(8'($urandom_range(255)));
      default: ;
    endcase
    send_text();
  endtask

  initial begin
    string directed [12] = '{"", " \t\r\n", "[]", "{}", " true ", "fals", "nul",
                             "-0.5e+10", "01", "1.", "\"\\uDC00\"", "[1 2]"};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty text, whitespace only, literals, number edges, surrogates
    foreach (directed[i]) begin
      add_str(directed[i]);
      send_text();
    end

    // four phases of idling and back-pressure with random texts
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      while (items_sent < 40 + (ph + 1) * 100) random_text();
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d texts in %0d input transactions, %0d end verdicts checked",
             texts_sent, items_sent, verdicts);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
